[src/gnss_binary_log_deframer_assert.svh]
// assertion macros for the binary log deframer checker
// clocked on clk_i and disabled while rst_ni is low
`ifndef GNSS_BINARY_LOG_DEFRAMER_ASSERT_SVH
`define GNSS_BINARY_LOG_DEFRAMER_ASSERT_SVH

// general property, sampled on the rising clock edge outside reset
`define GBLD_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

// a stalled valid item keeps its valid and its payload
`define GBLD_ASSERT_HOLD(lbl, vld, rdy, sig) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) \
    (vld && !rdy) |=> (vld && $stable(sig))) else $error("item changed while stalled");

`endif

[src/gbld_pkg.sv]
// shared types, constants and the crc step for the binary log deframer
// no dependencies
`timescale 1ns / 1ps

package gbld_pkg;

  // frame geometry
  localparam int HeaderBytes = 28;
  localparam int CrcBytes    = 4;
  localparam int CountW      = 17;

  // input queue between front and back
  localparam int QueueDepth = 2;
  localparam int QPtrW      = $clog2(QueueDepth);
  localparam int QCntW      = $clog2(QueueDepth + 1);

  // configuration port
  localparam int AddrW = 5;
  localparam int DataW = 32;

  // pipeline stages of the sync byte crc
  localparam int SyncCrcStages = 3;

  // sync pattern
  localparam logic [7:0]  SyncB2   = 8'h12;
  localparam logic [15:0] SyncHead = 16'hAA44;
  localparam logic [7:0]  SyncB0   = 8'hAA;
  localparam logic [7:0]  SyncB1   = 8'h44;

  // header byte positions
  localparam logic [CountW-1:0] PosIdLo   = CountW'(4);
  localparam logic [CountW-1:0] PosIdHi   = CountW'(5);
  localparam logic [CountW-1:0] PosType   = CountW'(6);
  localparam logic [CountW-1:0] PosLenLo  = CountW'(8);
  localparam logic [CountW-1:0] PosLenHi  = CountW'(9);
  localparam logic [CountW-1:0] PosWeekLo = CountW'(14);
  localparam logic [CountW-1:0] PosWeekHi = CountW'(15);
  localparam logic [CountW-1:0] PosTow0   = CountW'(16);
  localparam logic [CountW-1:0] PosTow1   = CountW'(17);
  localparam logic [CountW-1:0] PosTow2   = CountW'(18);
  localparam logic [CountW-1:0] PosTow3   = CountW'(19);
  localparam logic [CountW-1:0] SyncCount = CountW'(3);

  // frame status codes
  localparam logic [1:0] StatGood   = 2'd0;
  localparam logic [1:0] StatCrcBad = 2'd1;
  localparam logic [1:0] StatLenBad = 2'd2;

  // message type and class codes
  localparam logic [1:0] TypeBinary  = 2'd0;
  localparam logic [2:0] ClsOther    = 3'd0;
  localparam logic [2:0] ClsRange    = 3'd1;
  localparam logic [2:0] ClsGpsEph   = 3'd2;
  localparam logic [2:0] ClsBdsEph   = 3'd3;
  localparam logic [2:0] ClsBestPos  = 3'd4;

  // register indexes
  typedef enum logic [2:0] {
    REG_POLY    = 3'd0,
    REG_MAX_LEN = 3'd1,
    REG_RANGE   = 3'd2,
    REG_GPS_EPH = 3'd3,
    REG_BDS_EPH = 3'd4,
    REG_BESTPOS = 3'd5
  } reg_idx_e;

  // parser phase
  typedef enum logic [1:0] {
    PH_HUNT = 2'd0,
    PH_HEAD = 2'd1,
    PH_BODY = 2'd2
  } phase_e;

  // configuration seen by the parser
  typedef struct packed {
    logic [31:0] poly;
    logic [15:0] max_len;
    logic [15:0] range_id;
    logic [15:0] gps_id;
    logic [15:0] bds_id;
    logic [15:0] best_id;
  } cfg_t;

  // one frame summary
  typedef struct packed {
    logic [1:0]  status;
    logic [15:0] id;
    logic [1:0]  mtype;
    logic [15:0] length;
    logic [15:0] week;
    logic [31:0] tow;
    logic [2:0]  mclass;
  } frame_t;

  // reflected crc over one byte, one polynomial step per bit
  function automatic logic [31:0] crc_byte(input logic [31:0] crc, input logic [7:0] b,
                                           input logic [31:0] poly);
    logic [31:0] c;
    c = crc ^ {24'd0, b};
    for (int k = 0; k < 8; k++) begin
      c = c[0] ? ((c >> 1) ^ poly) : (c >> 1);
    end
    return c;
  endfunction

endpackage

[src/gbld_front.sv]
// front part: accepts stream bytes into a short queue for the parser
// depends on gbld_pkg
`timescale 1ns / 1ps

module gbld_front (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_ready_o,
  input  logic [7:0] data_byte_i,
  output logic       q_valid_o,
  output logic [7:0] q_byte_o,
  input  logic       q_pop_i
);
  import gbld_pkg::*;

  logic [7:0]       mem_q [QueueDepth];
  logic [QPtrW-1:0] wr_ptr_q, wr_ptr_d;
  logic [QPtrW-1:0] rd_ptr_q, rd_ptr_d;
  logic [QCntW-1:0] cnt_q, cnt_d;
  logic             push, pop;

  // handshake
  assign in_ready_o = (cnt_q != QCntW'(QueueDepth));
  assign q_valid_o  = (cnt_q != '0);
  assign q_byte_o   = mem_q[rd_ptr_q];
  assign push       = in_valid_i && in_ready_o;
  assign pop        = q_pop_i && q_valid_o;

  // pointer and fill count update
  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    cnt_d    = cnt_q;
    if (push) begin
      wr_ptr_d = (wr_ptr_q == QPtrW'(QueueDepth - 1)) ? '0 : wr_ptr_q + 1'b1;
    end
    if (pop) begin
      rd_ptr_d = (rd_ptr_q == QPtrW'(QueueDepth - 1)) ? '0 : rd_ptr_q + 1'b1;
    end
    if (push && !pop) begin
      cnt_d = cnt_q + 1'b1;
    end else if (pop && !push) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  // byte storage
  always_ff @(posedge clk_i) begin
    if (push) begin
      mem_q[wr_ptr_q] <= data_byte_i;
    end
  end

endmodule

[src/gbld_back.sv]
// back part: sync hunt, header capture, length and crc check and summary output register
// depends on gbld_pkg
`timescale 1ns / 1ps

module gbld_back (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  gbld_pkg::cfg_t   cfg_i,
  input  logic             q_valid_i,
  input  logic [7:0]       q_byte_i,
  output logic             q_pop_o,
  output logic             out_valid_o,
  input  logic             out_ready_i,
  output gbld_pkg::frame_t out_o
);
  import gbld_pkg::*;

  phase_e            phase_q, phase_d;
  logic [15:0]       win_q, win_d;
  logic [CountW-1:0] cnt_q, cnt_d;
  logic [31:0]       crc_q, crc_d;
  logic [15:0]       id_q, id_d;
  logic [1:0]        type_q, type_d;
  logic [15:0]       len_q, len_d;
  logic [15:0]       week_q, week_d;
  logic [31:0]       tow_q, tow_d;
  logic [31:0]       rcrc_q, rcrc_d;
  logic [31:0]       pre1_q, pre2_q, pre3_q;
  logic [31:0]       poly_q;
  logic [1:0]        pre_wait_q, pre_wait_d;
  logic              out_valid_q, out_valid_d;
  frame_t            out_q, out_d;

  logic              pop, emit, poly_chg;
  logic [1:0]        emit_status;
  logic [CountW-1:0] cnt_inc, body_end;
  logic [1:0]        crc_k;
  logic [2:0]        cls;

  // parser takes a byte whenever the output slot can take a summary
  // and the sync crc stages hold the current polynomial
  assign poly_chg = (cfg_i.poly != poly_q);
  assign pop      = q_valid_i && (!out_valid_q || out_ready_i) && !poly_chg &&
                    (pre_wait_q == '0);
  assign q_pop_o  = pop;
  assign cnt_inc  = cnt_q + 1'b1;
  assign body_end = CountW'(HeaderBytes) + {1'b0, len_q};
  assign crc_k    = 2'(cnt_q - body_end);

  // crc of the sync bytes, staged one byte per cycle off the polynomial
  always_ff @(posedge clk_i) begin
    pre1_q <= crc_byte(32'd0, SyncB0, cfg_i.poly);
    pre2_q <= crc_byte(pre1_q, SyncB1, cfg_i.poly);
    pre3_q <= crc_byte(pre2_q, SyncB2, cfg_i.poly);
  end

  // hold the parser while the sync crc stages refill after reset or a new polynomial
  always_comb begin
    pre_wait_d = pre_wait_q;
    if (poly_chg) begin
      pre_wait_d = 2'(SyncCrcStages - 1);
    end else if (pre_wait_q != '0) begin
      pre_wait_d = pre_wait_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      poly_q     <= '0;
      pre_wait_q <= 2'(SyncCrcStages);
    end else begin
      poly_q     <= cfg_i.poly;
      pre_wait_q <= pre_wait_d;
    end
  end

  // message class, first matching id wins
  always_comb begin
    cls = ClsOther;
    if (emit_status == StatGood && type_q == TypeBinary) begin
      if (id_q == cfg_i.range_id) begin
        cls = ClsRange;
      end else if (id_q == cfg_i.gps_id) begin
        cls = ClsGpsEph;
      end else if (id_q == cfg_i.bds_id) begin
        cls = ClsBdsEph;
      end else if (id_q == cfg_i.best_id) begin
        cls = ClsBestPos;
      end
    end
  end

  // next state of the parser
  always_comb begin
    phase_d     = phase_q;
    win_d       = win_q;
    cnt_d       = cnt_q;
    crc_d       = crc_q;
    id_d        = id_q;
    type_d      = type_q;
    len_d       = len_q;
    week_d      = week_q;
    tow_d       = tow_q;
    rcrc_d      = rcrc_q;
    emit        = 1'b0;
    emit_status = StatGood;
    if (pop) begin
      case (phase_q)
        PH_HEAD: begin
          crc_d = crc_byte(crc_q, q_byte_i, cfg_i.poly);
          cnt_d = cnt_inc;
          case (cnt_q)
            PosIdLo:   id_d        = {8'd0, q_byte_i};
            PosIdHi:   id_d[15:8]  = q_byte_i;
            PosType:   type_d      = q_byte_i[5:4];
            PosLenLo:  len_d       = {8'd0, q_byte_i};
            PosLenHi:  len_d[15:8] = q_byte_i;
            PosWeekLo: week_d      = {8'd0, q_byte_i};
            PosWeekHi: week_d[15:8] = q_byte_i;
            PosTow0:   tow_d       = {24'd0, q_byte_i};
            PosTow1:   tow_d[15:8] = q_byte_i;
            PosTow2:   tow_d[23:16] = q_byte_i;
            PosTow3:   tow_d[31:24] = q_byte_i;
            default:   ;
          endcase
          if (cnt_inc >= CountW'(HeaderBytes)) begin
            if (len_q > cfg_i.max_len) begin
              emit        = 1'b1;
              emit_status = StatLenBad;
              phase_d     = PH_HUNT;
              win_d       = '0;
              cnt_d       = '0;
            end else begin
              phase_d = PH_BODY;
              rcrc_d  = '0;
            end
          end
        end
        PH_BODY: begin
          cnt_d = cnt_inc;
          if (cnt_q < body_end) begin
            crc_d = crc_byte(crc_q, q_byte_i, cfg_i.poly);
          end else begin
            rcrc_d[8*crc_k +: 8] = q_byte_i;
            if ((cnt_inc - body_end) >= CountW'(CrcBytes)) begin
              emit        = 1'b1;
              emit_status = (rcrc_d == crc_q) ? StatGood : StatCrcBad;
              phase_d     = PH_HUNT;
              win_d       = '0;
              cnt_d       = '0;
            end
          end
        end
        default: begin
          // hunting, also the unused phase code
          if (win_q == SyncHead && q_byte_i == SyncB2) begin
            phase_d = PH_HEAD;
            cnt_d   = SyncCount;
            crc_d   = pre3_q;
            id_d    = '0;
            type_d  = '0;
            len_d   = '0;
            week_d  = '0;
            tow_d   = '0;
            rcrc_d  = '0;
            win_d   = '0;
          end else begin
            phase_d = PH_HUNT;
            win_d   = {win_q[7:0], q_byte_i};
          end
        end
      endcase
    end
  end

  // output register
  always_comb begin
    out_valid_d = out_valid_q;
    out_d       = out_q;
    if (emit) begin
      out_valid_d  = 1'b1;
      out_d.status = emit_status;
      out_d.id     = id_d;
      out_d.mtype  = type_d;
      out_d.length = len_d;
      out_d.week   = week_d;
      out_d.tow    = tow_d;
      out_d.mclass = cls;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q     <= PH_HUNT;
      win_q       <= '0;
      cnt_q       <= '0;
      crc_q       <= '0;
      id_q        <= '0;
      type_q      <= '0;
      len_q       <= '0;
      week_q      <= '0;
      tow_q       <= '0;
      rcrc_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      phase_q     <= phase_d;
      win_q       <= win_d;
      cnt_q       <= cnt_d;
      crc_q       <= crc_d;
      id_q        <= id_d;
      type_q      <= type_d;
      len_q       <= len_d;
      week_q      <= week_d;
      tow_q       <= tow_d;
      rcrc_q      <= rcrc_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_q <= out_d;
  end

  assign out_valid_o = out_valid_q;
  assign out_o       = out_q;

endmodule

[src/gnss_binary_log_deframer.sv]
// output: a frame's last byte passes the input queue and the parser into the summary register
// throughput: one byte per cycle while the output slot is free or being read and no crc
// refill holds the parser; a two-entry input queue absorbs two bytes while a summary waits
// crc: eight polynomial steps per byte per cycle; a polynomial write holds the parser
// reset: registers take their reset values, no clearing pass; hunting starts after the crc refill
// top level: configuration registers, input queue and parser, depends on gbld_pkg
`timescale 1ns / 1ps

module gnss_binary_log_deframer (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       psel,
  input  logic                       penable,
  input  logic                       pwrite,
  input  logic [gbld_pkg::AddrW-1:0] paddr,
  input  logic [gbld_pkg::DataW-1:0] pwdata,
  output logic [gbld_pkg::DataW-1:0] prdata,
  output logic                       pready,
  input  logic                       in_valid_i,
  output logic                       in_ready_o,
  input  logic [7:0]                 data_byte_i,
  output logic                       out_valid_o,
  input  logic                       out_ready_i,
  output logic [1:0]                 frame_status_o,
  output logic [15:0]                message_id_o,
  output logic [1:0]                 message_type_o,
  output logic [15:0]                body_length_o,
  output logic [15:0]                gps_week_o,
  output logic [31:0]                week_milliseconds_o,
  output logic [2:0]                 message_class_o
);
  import gbld_pkg::*;

  cfg_t       cfg_q;
  reg_idx_e   reg_idx;
  logic       wr_en;
  logic       q_valid, q_pop;
  logic [7:0] q_byte;
  frame_t     frame;

  // register write and read
  assign pready  = 1'b1;
  assign reg_idx = reg_idx_e'(paddr[AddrW-1:2]);
  assign wr_en   = psel && penable && pwrite;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.poly     <= 32'hEDB8_8320;
      cfg_q.max_len  <= 16'd16384;
      cfg_q.range_id <= 16'd43;
      cfg_q.gps_id   <= 16'd7;
      cfg_q.bds_id   <= 16'd1696;
      cfg_q.best_id  <= 16'd42;
    end else if (wr_en) begin
      case (reg_idx)
        REG_POLY:    cfg_q.poly     <= pwdata;
        REG_MAX_LEN: cfg_q.max_len  <= pwdata[15:0];
        REG_RANGE:   cfg_q.range_id <= pwdata[15:0];
        REG_GPS_EPH: cfg_q.gps_id   <= pwdata[15:0];
        REG_BDS_EPH: cfg_q.bds_id   <= pwdata[15:0];
        REG_BESTPOS: cfg_q.best_id  <= pwdata[15:0];
        default:     ;
      endcase
    end
  end

  always_comb begin
    case (reg_idx)
      REG_POLY:    prdata = cfg_q.poly;
      REG_MAX_LEN: prdata = {16'd0, cfg_q.max_len};
      REG_RANGE:   prdata = {16'd0, cfg_q.range_id};
      REG_GPS_EPH: prdata = {16'd0, cfg_q.gps_id};
      REG_BDS_EPH: prdata = {16'd0, cfg_q.bds_id};
      REG_BESTPOS: prdata = {16'd0, cfg_q.best_id};
      default:     prdata = '0;
    endcase
  end

  // input queue
  gbld_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .data_byte_i (data_byte_i),
    .q_valid_o   (q_valid),
    .q_byte_o    (q_byte),
    .q_pop_i     (q_pop)
  );

  // parser and summary register
  gbld_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg_q),
    .q_valid_i   (q_valid),
    .q_byte_i    (q_byte),
    .q_pop_o     (q_pop),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_o       (frame)
  );

  assign frame_status_o      = frame.status;
  assign message_id_o        = frame.id;
  assign message_type_o      = frame.mtype;
  assign body_length_o       = frame.length;
  assign gps_week_o          = frame.week;
  assign week_milliseconds_o = frame.tow;
  assign message_class_o     = frame.mclass;

endmodule

[src/gbld_checker.sv]
// port-level checks on the deframer summaries, bound to the top level
// depends on gbld_pkg and gnss_binary_log_deframer_assert.svh
`timescale 1ns / 1ps
`include "gnss_binary_log_deframer_assert.svh"

module gbld_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        out_valid_o,
  input logic        out_ready_i,
  input logic [1:0]  frame_status_o,
  input logic [15:0] message_id_o,
  input logic [1:0]  message_type_o,
  input logic [2:0]  message_class_o
);
  import gbld_pkg::*;

  // a waiting summary holds its valid and its message id
  `GBLD_ASSERT_HOLD(a_out_hold, out_valid_o, out_ready_i, message_id_o)

  // status is one of the three frame outcomes
  `GBLD_ASSERT(a_status_code, out_valid_o |-> (frame_status_o != 2'd3), "bad frame status")

  // a class only for good binary frames
  `GBLD_ASSERT(a_class_good, (out_valid_o && message_class_o != ClsOther) |-> (frame_status_o == StatGood && message_type_o == TypeBinary), "class on a bad or non-binary frame")

  // class within the known set
  `GBLD_ASSERT(a_class_range, out_valid_o |-> (message_class_o <= ClsBestPos), "class out of range")

endmodule

bind gnss_binary_log_deframer gbld_checker u_gbld_checker (.*);
